// ----- rtl/ss_pkg.sv -----
// Shared types and constants for the stride scheduler.
// No dependencies.
package ss_pkg;
	localparam int JOB_SLOTS_DEF = 16;
	localparam logic [13:0] STRIDE_BASE = 14'd10000;
	localparam int PASS_W = 32;
	localparam int STRIDE_W = 14;
	localparam int TIME_W = 16;
	localparam int CLK_W = 32;

	typedef enum logic [0:0] {
		OP_LOAD = 1'b0,
		OP_TICK = 1'b1
	} op_t;

	// controller to datapath commands
	typedef struct packed {
		logic div_start;   // latch load operands, begin divide
		logic div_step;    // one quotient bit
		logic load_wr;     // write slot
		logic scan_clr;    // reset search
		logic scan_step;   // compare one slot
		logic run_upd;     // update picked slot and clock
		logic emit_idle;   // strobe an idle result
		logic emit_run;    // strobe a run result
	} ss_cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic div_last;
		logic scan_last;
		logic found;
	} ss_sts_t;
endpackage

// ----- rtl/stride_scheduler.sv -----
// Stride scheduler top level: controller plus datapath, switch time register.
// Depends on ss_pkg, ss_ctrl, ss_dp.
//
// channel   direction  handshake            payload
// command   in         start & !busy        op, slot, tickets, svc_time
// result    out        strobe, one cycle    idle, job, first_run, start_time,
//                                           finished, clock_after
// config    in         cfg_valid&cfg_ready  cfg_data (switch_time)
//
// A tick runs the min search, one compare per slot, then an update step (or an
// idle result if no slot is live); the result strobes the cycle after. A load
// runs the 14-step restoring divider, then writes the slot. Reset clears all
// slots to finished. The receiver cannot stall; busy holds off new items.
module stride_scheduler #(
	parameter int JOB_SLOTS = ss_pkg::JOB_SLOTS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        op,
	input  logic [3:0]  slot,
	input  logic [13:0] tickets,
	input  logic [15:0] svc_time,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  cfg_data,
	output logic        strobe,
	output logic        idle,
	output logic [3:0]  job,
	output logic        first_run,
	output logic [31:0] start_time,
	output logic        finished,
	output logic [31:0] clock_after
);
	import ss_pkg::*;

	ss_cmd_t cmd;
	ss_sts_t sts;
	logic [7:0] switch_q;

	// hold switch time
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) switch_q <= '0;
		else if (cfg_valid) switch_q <= cfg_data;
	end

	ss_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .op(op),
		.sts(sts), .busy(busy), .cmd(cmd)
	);

	ss_dp #(.JOB_SLOTS(JOB_SLOTS)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .slot(slot), .tickets(tickets),
		.svc_time(svc_time), .switch_time(switch_q), .sts(sts),
		.strobe(strobe), .idle(idle), .job(job), .first_run(first_run),
		.start_time(start_time), .finished(finished), .clock_after(clock_after)
	);

	// a result follows only a completed item
	a_strobe_busy: assert property (@(posedge clk) disable iff (!arst_n)
		strobe |-> $past(busy)) else $error("strobe without item");
	// load, run, scan and divide step commands never overlap
	a_cmd_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.load_wr, cmd.run_upd, cmd.scan_step, cmd.div_step}))
		else $error("overlapping commands");
	// an accepted item makes the block busy
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy) else $error("item not taken");
endmodule

// ----- rtl/ss_ctrl.sv -----
// Controller state machine for the stride scheduler.
// Depends on ss_pkg.
module ss_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  logic           op,
	input  ss_pkg::ss_sts_t sts,
	output logic           busy,
	output ss_pkg::ss_cmd_t cmd
);
	import ss_pkg::*;

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_DIV  = 5'b00010,
		ST_WR   = 5'b00100,
		ST_SCAN = 5'b01000,
		ST_RUN  = 5'b10000
	} state_t;

	state_t state_q, state_d;

	// next state and commands
	always_comb begin
		state_d = state_q;
		cmd = '0;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					if (op == OP_LOAD) begin
						cmd.div_start = 1'b1;
						state_d = ST_DIV;
					end else begin
						cmd.scan_clr = 1'b1;
						state_d = ST_SCAN;
					end
				end
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_last) state_d = ST_WR;
			end
			ST_WR: begin
				cmd.load_wr = 1'b1;
				cmd.emit_idle = 1'b1;
				state_d = ST_IDLE;
			end
			ST_SCAN: begin
				cmd.scan_step = 1'b1;
				if (sts.scan_last) state_d = ST_RUN;
			end
			ST_RUN: begin
				if (sts.found) begin
					cmd.run_upd = 1'b1;
					cmd.emit_run = 1'b1;
				end else begin
					cmd.emit_idle = 1'b1;
				end
				state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	assign busy = (state_q != ST_IDLE);
endmodule

// ----- rtl/ss_dp.sv -----
// Datapath for the stride scheduler: slot registers, divider, min search, clock.
// Depends on ss_pkg.
module ss_dp #(
	parameter int JOB_SLOTS = ss_pkg::JOB_SLOTS_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  ss_pkg::ss_cmd_t cmd,
	input  logic [3:0]      slot,
	input  logic [13:0]     tickets,
	input  logic [15:0]     svc_time,
	input  logic [7:0]      switch_time,
	output ss_pkg::ss_sts_t sts,
	output logic            strobe,
	output logic            idle,
	output logic [3:0]      job,
	output logic            first_run,
	output logic [31:0]     start_time,
	output logic            finished,
	output logic [31:0]     clock_after
);
	import ss_pkg::*;

	localparam int IW = (JOB_SLOTS > 1) ? $clog2(JOB_SLOTS) : 1;
	localparam int CW = $clog2(JOB_SLOTS + 1);

	logic [PASS_W-1:0]   pass_q   [JOB_SLOTS];
	logic [STRIDE_W-1:0] stride_q [JOB_SLOTS];
	logic [TIME_W-1:0]   rem_q    [JOB_SLOTS];
	logic [TIME_W-1:0]   tot_q    [JOB_SLOTS];
	logic                prev_v_q;
	logic [IW-1:0]       prev_q;
	logic [CLK_W-1:0]    clk_q;

	// load operands and restoring divider
	logic [3:0]          ld_slot_q;
	logic [TIME_W-1:0]   ld_svc_q;
	logic [STRIDE_W-1:0] div_d_q, quo_q;
	logic [STRIDE_W:0]   rem_div_q;
	logic [3:0]          div_cnt_q;
	logic [STRIDE_W:0]   trial, shifted;
	logic [IW-1:0]       ld_idx;
	logic                ld_ok;

	assign shifted = {rem_div_q[STRIDE_W-1:0], STRIDE_BASE[div_cnt_q]};
	assign trial = shifted - {1'b0, div_d_q};
	assign ld_idx = IW'(ld_slot_q);
	assign ld_ok = ({28'd0, ld_slot_q} < 32'(JOB_SLOTS));

	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			ld_slot_q <= slot;
			ld_svc_q <= svc_time;
			div_d_q <= (tickets == '0) ? 14'd1 : tickets;
			rem_div_q <= '0;
			quo_q <= '0;
		end else if (cmd.div_step) begin
			if (!trial[STRIDE_W]) begin
				rem_div_q <= trial;
				quo_q <= {quo_q[STRIDE_W-2:0], 1'b1};
			end else begin
				rem_div_q <= shifted;
				quo_q <= {quo_q[STRIDE_W-2:0], 1'b0};
			end
		end
	end

	// count divider bits from msb down
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) div_cnt_q <= 4'd13;
		else if (cmd.div_start) div_cnt_q <= 4'd13;
		else if (cmd.div_step) div_cnt_q <= div_cnt_q - 4'd1;
	end
	assign sts.div_last = (div_cnt_q == 4'd0);

	// sequential min search, one slot per cycle
	logic [CW-1:0]     scan_q;
	logic              found_q;
	logic [IW-1:0]     pick_q;
	logic [PASS_W-1:0] best_q;
	logic [IW-1:0]     sidx;

	assign sidx = scan_q[IW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_q <= '0;
			found_q <= 1'b0;
		end else if (cmd.scan_clr) begin
			scan_q <= '0;
			found_q <= 1'b0;
		end else if (cmd.scan_step) begin
			scan_q <= scan_q + CW'(1);
			if (rem_q[sidx] != '0 && (!found_q || pass_q[sidx] < best_q)) begin
				found_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.scan_step && rem_q[sidx] != '0 && (!found_q || pass_q[sidx] < best_q)) begin
			pick_q <= sidx;
			best_q <= pass_q[sidx];
		end
	end

	assign sts.scan_last = (scan_q == CW'(JOB_SLOTS - 1));
	assign sts.found = found_q;

	// run step values
	logic [CLK_W-1:0]  st_time;
	logic [TIME_W-1:0] rem_next;
	assign st_time = (prev_v_q && prev_q != pick_q) ? clk_q + CLK_W'(switch_time) : clk_q;
	assign rem_next = rem_q[pick_q] - TIME_W'(1);

	// slot state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < JOB_SLOTS; i++) begin
				pass_q[i] <= '0;
				stride_q[i] <= '0;
				rem_q[i] <= '0;
				tot_q[i] <= '0;
			end
			prev_v_q <= 1'b0;
			prev_q <= '0;
			clk_q <= '0;
		end else if (cmd.load_wr) begin
			if (ld_ok) begin
				pass_q[ld_idx] <= '0;
				stride_q[ld_idx] <= quo_q;
				rem_q[ld_idx] <= ld_svc_q;
				tot_q[ld_idx] <= ld_svc_q;
			end
		end else if (cmd.run_upd) begin
			pass_q[pick_q] <= pass_q[pick_q] + PASS_W'(stride_q[pick_q]);
			rem_q[pick_q] <= rem_next;
			prev_v_q <= 1'b1;
			prev_q <= pick_q;
			clk_q <= st_time + CLK_W'(1);
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) strobe <= 1'b0;
		else strobe <= cmd.emit_idle | cmd.emit_run;
	end

	always_ff @(posedge clk) begin
		if (cmd.emit_run) begin
			idle <= 1'b0;
			job <= 4'(pick_q);
			first_run <= (tot_q[pick_q] == rem_q[pick_q]);
			start_time <= st_time;
			finished <= (rem_next == '0);
			clock_after <= st_time + CLK_W'(1);
		end else if (cmd.emit_idle) begin
			idle <= 1'b1;
			job <= '0;
			first_run <= 1'b0;
			start_time <= '0;
			finished <= 1'b0;
			clock_after <= '0;
		end
	end
endmodule

// ----- tb/sv/tb.sv -----
`timescale 1ns / 1ps
// Testbench for stride_scheduler: random and directed job loads and ticks,
// checked against a predictor of the stride scheduling rules.
// Depends on ss_pkg and the stride_scheduler RTL.
module tb;
	import ss_pkg::*;

	typedef struct {
		logic        idle;
		logic [3:0]  job;
		logic        first_run;
		logic [31:0] start_time;
		logic        finished;
		logic [31:0] clock_after;
	} sched_res_t;

	// Scheduler predictor and queue of expected results.
	class sched_scoreboard;
		logic [31:0] pass_q[16];
		logic [13:0] stride_q[16];
		logic [15:0] left_q[16];
		logic [15:0] total_q[16];
		bit          prev_ok;
		logic [3:0]  prev_slot;
		logic [31:0] now;
		logic [7:0]  switch_cost;
		sched_res_t  pending[$];
		int          n_err;
		int          n_seen;
		int          n_runs;

		function new();
			for (int i = 0; i < 16; i++) begin
				pass_q[i] = 0; stride_q[i] = 0; left_q[i] = 0; total_q[i] = 0;
			end
			prev_ok = 0; prev_slot = 0; now = 0; switch_cost = 0;
			n_err = 0; n_seen = 0; n_runs = 0;
		endfunction

		// Predict the result of one accepted item.
		function void note_item(op_t o, logic [3:0] s, logic [13:0] t, logic [15:0] sv);
			sched_res_t r;
			int pick;
			logic [13:0] tk;
			r = '{1'b1, 4'd0, 1'b0, 32'd0, 1'b0, 32'd0};
			pick = -1;
			if (o == OP_LOAD) begin
				tk = (t == 0) ? 14'd1 : t;
				stride_q[s] = 14'(32'd10000 / tk);
				pass_q[s] = 0; left_q[s] = sv; total_q[s] = sv;
			end else begin
				for (int i = 0; i < 16; i++)
					if (left_q[i] != 0 && (pick < 0 || pass_q[i] < pass_q[pick]))
						pick = i;
				if (pick >= 0) begin
					if (prev_ok && prev_slot != 4'(pick)) now = now + switch_cost;
					r.idle = 0;
					r.job = 4'(pick);
					r.start_time = now;
					r.first_run = (total_q[pick] == left_q[pick]);
					now = now + 1;
					left_q[pick] = left_q[pick] - 1;
					pass_q[pick] = pass_q[pick] + stride_q[pick];
					r.finished = (left_q[pick] == 0);
					r.clock_after = now;
					prev_ok = 1; prev_slot = 4'(pick);
				end
			end
			pending.insert(pending.size(), r);
		endfunction

		function bit any_live();
			for (int i = 0; i < 16; i++) if (left_q[i] != 0) return 1;
			return 0;
		endfunction

		function void check_result(sched_res_t got);
			sched_res_t w;
			n_seen++;
			if (!got.idle) n_runs++;
			if (pending.size() == 0) begin
				report_err("result with nothing expected");
				return;
			end
			w = pending.pop_front();
			if (got.idle !== w.idle) report_err($sformatf("idle %0b want %0b", got.idle, w.idle));
			if (got.job !== w.job) report_err($sformatf("job %0d want %0d", got.job, w.job));
			if (got.first_run !== w.first_run)
				report_err($sformatf("first_run %0b want %0b", got.first_run, w.first_run));
			if (got.start_time !== w.start_time)
				report_err($sformatf("start_time %0d want %0d", got.start_time, w.start_time));
			if (got.finished !== w.finished)
				report_err($sformatf("finished %0b want %0b", got.finished, w.finished));
			if (got.clock_after !== w.clock_after)
				report_err($sformatf("clock_after %0d want %0d", got.clock_after, w.clock_after));
		endfunction

		function void report_err(string msg);
			n_err++;
			if (n_err <= 40) $display("MISMATCH @%0t: %s", $realtime, msg);
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        start;
	logic        busy;
	logic        op;
	logic [3:0]  slot;
	logic [13:0] tickets;
	logic [15:0] svc_time;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [7:0]  cfg_data;
	logic        strobe;
	logic        idle;
	logic [3:0]  job;
	logic        first_run;
	logic [31:0] start_time;
	logic        finished;
	logic [31:0] clock_after;

	sched_scoreboard sb;
	bit quiet_tail;

	stride_scheduler uut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .op(op), .slot(slot),
		.tickets(tickets), .svc_time(svc_time), .cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready), .cfg_data(cfg_data), .strobe(strobe), .idle(idle),
		.job(job), .first_run(first_run), .start_time(start_time), .finished(finished),
		.clock_after(clock_after)
	);

	always begin
		clk = 1'b0; #5;
		clk = 1'b1; #5;
	end

	// Check every strobed result.
	always @(posedge clk) begin
		if (arst_n && strobe)
			sb.check_result('{idle, job, first_run, start_time, finished, clock_after});
	end

	// Present one item, hold it until accepted, then drop start.
	task automatic send_item(op_t o, logic [3:0] s, logic [13:0] t, logic [15:0] sv);
		if (!quiet_tail && $urandom_range(0, 5) == 0)
			repeat ($urandom_range(1, 17)) @(posedge clk);
		start <= 1'b1;
		op <= o; slot <= s; tickets <= t; svc_time <= sv;
		do @(posedge clk); while (busy);
		sb.note_item(o, s, t, sv);
		start <= 1'b0;
		@(posedge clk);
	endtask

	// Wait for all results, let the block settle, then write switch time.
	task automatic write_switch(logic [7:0] v);
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		sb.switch_cost = v;
		cfg_valid <= 1'b0;
	endtask

	task automatic load_job(logic [3:0] s, logic [13:0] t, logic [15:0] sv);
		send_item(OP_LOAD, s, t, sv);
	endtask

	task automatic tick();
		send_item(OP_TICK, 4'($urandom), 14'($urandom), 16'($urandom));
	endtask

	// Random phase: loads, mostly with short service times, and mostly ticks.
	task automatic random_phase(int n);
		int k;
		k = 0;
		while (k < n) begin
			if ($urandom_range(0, 9) < 2 || !sb.any_live()) begin
				case ($urandom_range(0, 3))
					0: load_job(4'($urandom), 14'($urandom), 16'($urandom));
					1: load_job(4'($urandom), 14'($urandom_range(10001, 16383)),
						16'($urandom_range(1, 12)));
					default: load_job(4'($urandom), 14'($urandom_range(0, 10000)),
						16'($urandom_range(0, 12)));
				endcase
			end else begin
				tick();
			end
			k++;
		end
	endtask

	initial begin
		sb = new();
		quiet_tail = 0;
		start = 0; op = 0; slot = 0; tickets = 0; svc_time = 0;
		cfg_valid = 0; cfg_data = 0;
		arst_n = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Directed: empty tick, field extremes, ticket corners, reload.
		tick();
		write_switch(8'd0);
		load_job(4'd0, 14'd1, 16'd2);
		load_job(4'd15, 14'd10000, 16'd3);
		load_job(4'd7, 14'd0, 16'd1);
		load_job(4'd3, 14'd16383, 16'd2);
		load_job(4'd9, 14'd5, 16'd0);
		repeat (4) tick();
		load_job(4'd0, 14'd3, 16'd2);
		repeat (6) tick();
		tick();
		write_switch(8'd255);
		load_job(4'd1, 14'd2, 16'd2);
		load_job(4'd2, 14'd2, 16'd2);
		repeat (5) tick();
		load_job(4'd4, 14'd100, 16'hFFFF);
		repeat (3) tick();

		write_switch(8'd17);
		random_phase(600);
		write_switch(8'($urandom));
		random_phase(600);
		write_switch(8'd255);
		random_phase(300);
		write_switch(8'd0);
		quiet_tail = 1;
		random_phase(300);

		while (sb.pending.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		$display("Checked %0d results, %0d of them job runs, over four switch settings.",
			sb.n_seen, sb.n_runs);
		if (sb.n_err == 0 && sb.pending.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	initial begin
		#5ms;
		$display("Timeout");
		$display("*** FAILED ***");
		$finish;
	end
endmodule
